[hw/rtl/cht_pkg.sv]
// Package for the chained hash table: payload structs, sizes and operation codes.
// No dependencies.
package cht_pkg;

  localparam int unsigned MaxBucketsDefault = 16;
  localparam int unsigned KeyW = 32;
  localparam int unsigned SumW = 36;

  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncRemove = 2'd1;
  localparam logic [1:0] FuncSearch = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [3:0]         bucket;
    logic [4:0]         entry_count;
    logic signed [35:0] key_sum;
  } rsp_t;

endpackage

[hw/rtl/cht_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/chained_hash_table.sv]
// Chained hash table top level. Depends on cht_pkg and cht_ram.
// One word in, one word out per operation.
//
// A bounded hash table of signed 32-bit keys with separate chaining, working on one word
// at a time. A key maps to bucket (key & 0x7FFFFFFF) mod bucket_count. A bucket_count of
// 0 acts as 1, and one above MaxBuckets acts as MaxBuckets. The count is also the entry
// capacity. Insert appends the key at the tail of its chain and fails on a full table,
// remove unlinks the first matching node, and search reports a hit. Duplicate keys are
// allowed, and function code 3 changes nothing and always reports a failure. Every result
// word carries the bucket, the entry count and the running key sum. The remainder comes
// from a restoring divider that retires one bit of the 31-bit masked key per cycle, and
// that sets most of the latency. The divider is followed by a head read state and a head
// inspect state. Each chain node visited adds a read state and an inspect state, because
// the node memory has a registered read. A change to the table adds an update state, and
// a walk that runs off the end of its chain adds a last read state. The result word is
// registered as the done state is left. At the default size the slowest items are a search
// or a remove that misses on a chain of 16 nodes. The next input word is taken in the idle
// state that follows. A result that waits on a stalled receiver sits in the output register
// and holds back only the item behind it. Chain heads, node keys, node links and the free
// node stack live in synchronous RAMs. After reset and after every bucket_count write, a
// clearing pass over every bucket and node slot empties the table and refills the free stack
// while the input is stalled. A bucket_count write is taken only while nothing is in flight.
module chained_hash_table #(
  parameter int unsigned MaxBuckets = cht_pkg::MaxBucketsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cht_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cht_pkg::rsp_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [4:0]    cfg_data_i
);
  import cht_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxBuckets);
  localparam int unsigned PtrW = IdxW + 1;   // one extra bit for the null pointer
  localparam int unsigned CntW = $clog2(MaxBuckets + 1);
  localparam logic [PtrW-1:0] Nil = PtrW'(MaxBuckets);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxBuckets - 1);

  // Sequencer states.
  localparam logic [3:0] StClear  = 4'd0;
  localparam logic [3:0] StIdle   = 4'd1;
  localparam logic [3:0] StDiv    = 4'd2;
  localparam logic [3:0] StHead   = 4'd3;
  localparam logic [3:0] StHeadW  = 4'd4;
  localparam logic [3:0] StNode   = 4'd5;
  localparam logic [3:0] StNodeW  = 4'd6;
  localparam logic [3:0] StUpdate = 4'd7;
  localparam logic [3:0] StDone   = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [IdxW-1:0] clr_q;
  logic [1:0]      func_q;
  logic [KeyW-1:0] key_q;
  logic [4:0]      bcount_q;
  logic [IdxW:0]   cap_q;
  logic [30:0]     dvd_q;
  logic [IdxW:0]   rem_q;
  logic [4:0]      bit_q;
  logic [IdxW-1:0] pos_q;
  logic [PtrW-1:0] cur_q, prev_q;
  logic [IdxW-1:0] new_q;
  logic [CntW-1:0] count_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] free_top_q;
  logic            ok_q;
  logic            out_valid_q;
  rsp_t            out_q;

  // Memory ports.
  logic            head_we, key_we, next_we, free_we;
  logic [IdxW-1:0] head_wa, key_wa, next_wa, free_wa;
  logic [IdxW-1:0] head_ra, node_ra, free_ra;
  logic [PtrW-1:0] head_wd, next_wd, head_rd, next_rd;
  logic [KeyW-1:0] key_rd;
  logic [IdxW-1:0] free_wd, free_rd;

  cht_ram #(.Width(PtrW), .Depth(MaxBuckets)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd));
  cht_ram #(.Width(KeyW), .Depth(MaxBuckets)) u_key (
    .clk_i, .we_i(key_we), .waddr_i(key_wa), .wdata_i(key_q),
    .raddr_i(node_ra), .rdata_o(key_rd));
  cht_ram #(.Width(PtrW), .Depth(MaxBuckets)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(node_ra), .rdata_o(next_rd));
  cht_ram #(.Width(IdxW), .Depth(MaxBuckets)) u_free (
    .clk_i, .we_i(free_we), .waddr_i(free_wa), .wdata_i(free_wd),
    .raddr_i(free_ra), .rdata_o(free_rd));

  // Hash step: shift in the next dividend bit and subtract the divisor if it fits.
  logic [IdxW+1:0] trial;
  assign trial = {rem_q, dvd_q[30]} - {1'b0, cap_q};

  logic [IdxW:0] cap_eff;
  always_comb begin
    priority if (bcount_q == 5'd0) begin
      cap_eff = (IdxW+1)'(1);
    end else if (32'(bcount_q) > MaxBuckets) begin
      cap_eff = (IdxW+1)'(MaxBuckets);
    end else begin
      cap_eff = (IdxW+1)'(bcount_q);
    end
  end

  logic accept, cfg_take, out_free, key_hit, cur_nil, head_nil, next_nil, is_full;
  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == StIdle) && !out_valid_q && !in_valid_i;
  assign cfg_take    = cfg_valid_i && cfg_ready_o;
  // The output register can take a new result when it is empty or being drained.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign key_hit     = (key_rd == key_q);
  assign cur_nil     = (cur_q == Nil);
  assign head_nil    = (head_rd == Nil);
  assign next_nil    = (next_rd == Nil);
  assign is_full     = (32'(count_q) >= 32'(cap_q));

  logic [SumW-1:0] key_ext;
  assign key_ext = {{(SumW-KeyW){key_q[KeyW-1]}}, key_q};

  always_comb begin
    state_d = state_q;
    head_we = 1'b0; head_wa = pos_q; head_wd = Nil;
    head_ra = rem_q[IdxW-1:0];
    key_we  = 1'b0; key_wa = free_rd;
    next_we = 1'b0; next_wa = free_rd; next_wd = Nil;
    node_ra = cur_q[IdxW-1:0];
    free_we = 1'b0; free_wa = free_top_q[IdxW-1:0]; free_wd = cur_q[IdxW-1:0];
    free_ra = IdxW'(free_top_q - CntW'(1));
    unique case (state_q)
      StClear: begin
        // Every bucket becomes empty and the free stack holds every node.
        head_we = 1'b1; head_wa = clr_q;
        free_we = 1'b1; free_wa = clr_q; free_wd = clr_q;
        if (clr_q == LastIdx) state_d = StIdle;
      end
      StIdle: begin
        if (cfg_take) begin
          state_d = StClear;
        end else if (accept) begin
          state_d = StDiv;
        end
      end
      StDiv: if (bit_q == 5'd0) state_d = StHead;
      StHead: state_d = StHeadW;
      StHeadW: begin
        // The chain head and the top of the free stack are on the read ports now.
        unique case (func_q)
          FuncInsert: begin
            if (is_full) begin
              state_d = StDone;
            end else begin
              key_we  = 1'b1;
              next_we = 1'b1;
              if (head_nil) begin
                head_we = 1'b1;
                head_wd = PtrW'(free_rd);
                state_d = StUpdate;
              end else begin
                state_d = StNode;
              end
            end
          end
          FuncRemove: state_d = (count_q == '0) ? StDone : StNode;
          FuncSearch: state_d = StNode;
          default: state_d = StDone;
        endcase
      end
      StNode: state_d = cur_nil ? StDone : StNodeW;
      StNodeW: begin
        // Key and link of the current node are on the read ports now.
        unique case (func_q)
          FuncInsert: begin
            if (next_nil) begin
              next_we = 1'b1;
              next_wa = cur_q[IdxW-1:0];
              next_wd = PtrW'(new_q);
              state_d = StUpdate;
            end else begin
              state_d = StNode;
            end
          end
          FuncRemove: begin
            if (key_hit) begin
              if (prev_q == Nil) begin
                head_we = 1'b1;
                head_wd = next_rd;
              end else begin
                next_we = 1'b1;
                next_wa = prev_q[IdxW-1:0];
                next_wd = next_rd;
              end
              free_we = 1'b1;
              state_d = StUpdate;
            end else begin
              state_d = StNode;
            end
          end
          FuncSearch: state_d = key_hit ? StDone : StNode;
          default: state_d = StDone;
        endcase
      end
      StUpdate: state_d = StDone;
      StDone: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      bcount_q    <= 5'd16;
      count_q     <= '0;
      sum_q       <= '0;
      free_top_q  <= CntW'(MaxBuckets);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_take) begin
        bcount_q   <= cfg_data_i;
        count_q    <= '0;
        sum_q      <= '0;
        free_top_q <= CntW'(MaxBuckets);
        clr_q      <= '0;
      end else if (state_q == StClear) begin
        clr_q <= clr_q + IdxW'(1);
      end
      // The update state is reached only by a successful insert or remove.
      if (state_q == StUpdate) begin
        if (func_q == FuncInsert) begin
          count_q    <= count_q + CntW'(1);
          sum_q      <= sum_q + key_ext;
          free_top_q <= free_top_q - CntW'(1);
        end else begin
          count_q    <= count_q - CntW'(1);
          sum_q      <= sum_q - key_ext;
          free_top_q <= free_top_q + CntW'(1);
        end
      end
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk datapath. Each node visit: StNode issues the read, StNodeW inspects it.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          func_q <= in_data_i.func;
          key_q  <= in_data_i.key;
          dvd_q  <= in_data_i.key[30:0];
          cap_q  <= cap_eff;
          rem_q  <= '0;
          bit_q  <= 5'd30;
          ok_q   <= 1'b0;
        end
      end
      StDiv: begin
        bit_q <= bit_q - 5'd1;
        dvd_q <= {dvd_q[29:0], 1'b0};
        if (trial[IdxW+1]) rem_q <= {rem_q[IdxW-1:0], dvd_q[30]};
        else rem_q <= trial[IdxW:0];
      end
      StHead: pos_q <= rem_q[IdxW-1:0];
      StHeadW: begin
        cur_q  <= head_rd;
        prev_q <= Nil;
        new_q  <= free_rd;
        if (func_q == FuncInsert && !is_full && head_nil) ok_q <= 1'b1;
      end
      StNodeW: begin
        prev_q <= cur_q;
        cur_q  <= next_rd;
        if ((func_q == FuncInsert && next_nil) || (func_q != FuncInsert && key_hit)) begin
          ok_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && out_free) begin
      out_q.ok          <= ok_q;
      out_q.bucket      <= 4'(pos_q);
      out_q.entry_count <= 5'(count_q);
      out_q.key_sum     <= sum_q;
    end
  end
endmodule

[hw/rtl/cht_checker.sv]
// Port-level checker for the chained hash table, bound to the top level.
// Depends on cht_pkg.
module cht_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input cht_pkg::rsp_t out_data_o,
  input logic          cfg_valid_i,
  input logic          cfg_ready_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !out_valid_o)
    else $error("config ready while a result is pending");
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o && !cfg_ready_o)
    else $error("table not cleared after a config write");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= 5'd16)
    else $error("entry count beyond capacity");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while busy");
endmodule

bind chained_hash_table cht_checker u_cht_checker (.*);

[tb/sv/cht_checker.sv]
// Checker for the chained hash table: tracks the table contents from accepted words and
// compares every result word field by field. Depends on cht_pkg.
module cht_tb_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  cht_pkg::req_t in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  cht_pkg::rsp_t out_data_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  logic [4:0]    cfg_data_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);
  import cht_pkg::*;

  logic [4:0]  bucket_reg;
  logic [31:0] chain_keys [16][$];
  logic [4:0]  stored;
  logic [35:0] sum;
  rsp_t        expected_rsps [$];

  assign pending_o = expected_rsps.size();

  function automatic int unsigned live_buckets();
    if (bucket_reg == 5'd0) return 1;
    if (bucket_reg > 5'd16) return 16;
    return 32'(bucket_reg);
  endfunction

  function automatic void empty_table();
    for (int b = 0; b < 16; b++) chain_keys[b].delete();
    stored = '0;
    sum = '0;
  endfunction

  // Applies one operation to the tracked table and returns the result word it yields.
  function automatic rsp_t apply_op(req_t r);
    rsp_t        res;
    int unsigned cap;
    int unsigned pos;
    logic [31:0] k;
    cap = live_buckets();
    k = r.key;
    pos = (k & 32'h7FFF_FFFF) % cap;
    res.ok = 1'b0;
    case (r.func)
      FuncInsert: begin
        if (stored < cap) begin
          chain_keys[pos].push_back(k);
          stored++;
          sum = sum + {{4{k[31]}}, k};
          res.ok = 1'b1;
        end
      end
      FuncRemove: begin
        if (stored != 0) begin
          for (int i = 0; i < chain_keys[pos].size(); i++) begin
            if (!res.ok && chain_keys[pos][i] == k) begin
              chain_keys[pos].delete(i);
              stored--;
              sum = sum - {{4{k[31]}}, k};
              res.ok = 1'b1;
            end
          end
        end
      end
      FuncSearch: begin
        foreach (chain_keys[pos][i]) if (chain_keys[pos][i] == k) res.ok = 1'b1;
      end
      default: ;
    endcase
    res.bucket = pos[3:0];
    res.entry_count = stored;
    res.key_sum = sum;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      bucket_reg = 5'd16;
      empty_table();
      expected_rsps.delete();
      fail_count_o <= 0;
    end else begin
      // A register write empties the table, and it only happens while idle.
      if (cfg_valid_i && cfg_ready_i) begin
        bucket_reg = cfg_data_i;
        empty_table();
      end
      if (in_valid_i && !in_stall_i) expected_rsps.push_back(apply_op(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result word %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (want.ok !== out_data_i.ok || want.bucket !== out_data_i.bucket ||
              want.entry_count !== out_data_i.entry_count ||
              want.key_sum !== out_data_i.key_sum) begin
            if (fail_count_o < 10)
              $display("mismatch: expected ok %0d bucket %0d count %0d sum %0d,",
                       want.ok, want.bucket, want.entry_count, want.key_sum,
                       " got ok %0d bucket %0d count %0d sum %0d",
                       out_data_i.ok, out_data_i.bucket, out_data_i.entry_count,
                       out_data_i.key_sum);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[tb/sv/chained_hash_table_tb.sv]
// Testbench top for the chained hash table: drives operation words, bucket count writes
// and output stalls, and gives the verdict. Depends on cht_pkg and cht_tb_checker.
module chained_hash_table_tb;
  import cht_pkg::*;

  // The package names only the three real operations; the fourth code must do nothing.
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned HoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  req_t        in_data = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        in_stall;
  logic        out_valid;
  rsp_t        out_data;
  logic        cfg_ready;
  int unsigned fail_count;
  int unsigned pending;

  // Control shared between the sender and the receiver process.
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  logic [31:0] live_keys [$];
  int unsigned idle_cycles = 0;

  always #4 clk = ~clk;

  chained_hash_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  cht_tb_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Watchdog: a long run of cycles in which no word moves on any channel means the block
  // is stuck. The limit covers the long receiver hold-off plus the slowest item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, and none in the calm
  // final phase. Each pass sets the stall once and then advances time.
  initial begin
    @(posedge rst_n);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Offers one word and holds it until the block takes it. Valid stays high on return, apart from
  // random gaps outside the calm phase, so that back-to-back words need no second assignment in the
  // same step. The stall is sampled as the edge happens, so the accepting edge is found without a race.
  task automatic send_word(logic [1:0] func, logic [31:0] key);
    in_valid <= 1'b1;
    in_data <= '{func: func, key: key};
    @(posedge clk iff !in_stall);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Every word yields a result, so the table is idle once nothing is pending.
  task automatic write_buckets(logic [4:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    live_keys.delete();
  endtask

  // Mostly keys already in the table so removes and searches hit, some small keys to
  // crowd buckets and make duplicates, and some fully random keys to toggle every bit.
  function automatic logic [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && live_keys.size() != 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    if (sel < 8) return $urandom_range(0, 40) - 20;
    return $urandom;
  endfunction

  task automatic random_op();
    int unsigned sel;
    logic [31:0] key;
    sel = $urandom_range(0, 99);
    key = pick_key();
    if (sel < 42) begin
      send_word(FuncInsert, key);
      if (live_keys.size() < 40) live_keys.push_back(key);
    end else if (sel < 74) begin
      send_word(FuncRemove, key);
      foreach (live_keys[i]) if (live_keys[i] == key) begin
        live_keys.delete(i);
        break;
      end
    end else if (sel < 95) begin
      send_word(FuncSearch, key);
    end else begin
      send_word(FuncUnused, key);
    end
  endtask

  initial begin
    logic [4:0] settings [8];
    settings = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd5, 5'd2, 5'd16, 5'd0};
    settings[7] = 5'($urandom_range(0, 31));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset bucket count of 16: sign extremes, duplicates, hits and
    // misses, the unused code, and a fill up to capacity with one insert that overflows.
    send_word(FuncInsert, 32'h0000_0000);
    send_word(FuncInsert, 32'hFFFF_FFFF);
    send_word(FuncInsert, 32'h8000_0000);
    send_word(FuncInsert, 32'h7FFF_FFFF);
    send_word(FuncInsert, 32'h0000_0000);
    send_word(FuncSearch, 32'h0000_0000);
    send_word(FuncSearch, 32'h8000_0000);
    send_word(FuncSearch, 32'h0000_0005);
    send_word(FuncRemove, 32'h0000_0000);
    send_word(FuncSearch, 32'h0000_0000);
    send_word(FuncRemove, 32'h0000_3039);
    send_word(FuncUnused, 32'hDEAD_BEEF);
    // All of these share bucket zero, which builds a long chain in one bucket.
    for (int i = 1; i <= 13; i++) send_word(FuncInsert, i * 16);

    // Random phases, each under its own bucket count, starting with a remove on the
    // freshly emptied table.
    for (int ph = 0; ph < 8; ph++) begin
      write_buckets(settings[ph]);
      if (ph == 7) calm = 1'b1;
      send_word(FuncRemove, pick_key());
      for (int n = 0; n < 100; n++) begin
        // Fill up the block while the receiver holds off for a long stretch.
        if (ph == 3 && n == 10) hold_req = 1'b1;
        // Let the block run completely dry once in the middle of a phase.
        if (ph == 4 && n == 50) wait_drained();
        random_op();
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
